// File: sv/ssg_pkg.sv
// Package for the stepper step generator with homing: command codes, register
// indexes, reset values and the one-hot motion state type with its status code.
// No dependencies.
`default_nettype none

package ssg_pkg;

	// Fixed widths of the channel fields and registers.
	localparam int KIND_W       = 3;
	localparam int STEPS_W      = 32;
	localparam int MODE_W       = 3;
	localparam int PERIOD_REG_W = 20;
	localparam int OFFSET_REG_W = 16;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 32;

	// Default sizes of the internal counters.
	localparam int DEF_COUNT_WIDTH  = 32;
	localparam int DEF_PERIOD_WIDTH = 20;

	// Register reset values.
	localparam logic [PERIOD_REG_W-1:0] STEP_PERIOD_RST = PERIOD_REG_W'(1000);
	localparam logic [OFFSET_REG_W-1:0] HOME_OFFSET_RST = OFFSET_REG_W'(100);

	// Register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_PERIOD = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_HOME_OFFSET = CFG_INDEX_W'(1);

	// Command codes.
	localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MOVE      = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CONTINUOUS = 3'd2;
	localparam logic [KIND_W-1:0] KIND_HOME      = 3'd3;
	localparam logic [KIND_W-1:0] KIND_STOP      = 3'd4;

	// Status codes reported on the mode field.
	localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_MOVING  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SEEK    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_OFFSET  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_AT_HOME = 3'd4;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MOVING = 5'b00010,
		ST_SEEK   = 5'b00100,
		ST_OFFSET = 5'b01000,
		ST_HOME   = 5'b10000
	} motion_t;

	// Maps the one-hot motion state to the status code on the result.
	function automatic logic [MODE_W-1:0] mode_code(input motion_t m);
		logic [MODE_W-1:0] c;
		case (m)
			ST_IDLE:   c = MODE_IDLE;
			ST_MOVING: c = MODE_MOVING;
			ST_SEEK:   c = MODE_SEEK;
			ST_OFFSET: c = MODE_OFFSET;
			ST_HOME:   c = MODE_AT_HOME;
			default:   c = MODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// File: sv/stepper_step_generator_homing.sv
// Top level of the stepper step generator with homing: input register, motion
// state update and result register. Depends on ssg_pkg.
`default_nettype none

// Channel | Direction | Handshake            | Beat carries
// --------+-----------+----------------------+-------------------------------------------
// in      | to block  | in_valid / in_ready  | kind, steps, direction, sensor_level
// out     | from block| out_valid / out_ready| step_pulse, dir_level, mode, homed,
//         |           |                      | homing_complete
// cfg     | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Every input beat gives exactly one result beat through the input register and the
// result register. One beat a cycle is sustained while the output side is ready: the
// input register and the result register each hold one beat and the motion state is
// updated in one pass. Reset clears the motion state and loads the register defaults
// (period 1000 ticks, home offset 100 steps). A stalled result register stalls the
// input register; the input side keeps taking beats as long as the input register
// can move on. Configuration writes are always taken in the cycle they are offered.

module stepper_step_generator_homing #(
	parameter int COUNT_WIDTH  = ssg_pkg::DEF_COUNT_WIDTH,
	parameter int PERIOD_WIDTH = ssg_pkg::DEF_PERIOD_WIDTH
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// Input channel.
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  [ssg_pkg::KIND_W-1:0]           kind,
	input  wire  [ssg_pkg::STEPS_W-1:0]          steps,
	input  wire                                  direction,
	input  wire                                  sensor_level,
	// Result channel.
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic                                 step_pulse,
	output logic                                 dir_level,
	output logic [ssg_pkg::MODE_W-1:0]           mode,
	output logic                                 homed,
	output logic                                 homing_complete,
	// Configuration write channel.
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [ssg_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire  [ssg_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// Largest goal the step counter can reach, as a 32-bit value for comparing
	// against the wider command fields.
	localparam logic [31:0] CNT_MAX32 = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

	// Configuration registers.
	logic [ssg_pkg::PERIOD_REG_W-1:0] step_period_q;
	logic [ssg_pkg::OFFSET_REG_W-1:0] home_offset_q;

	// Input register.
	logic                          valid_s1;
	logic [ssg_pkg::KIND_W-1:0]    kind_s1;
	logic [ssg_pkg::STEPS_W-1:0]   steps_s1;
	logic                          direction_s1;
	logic                          sensor_level_s1;

	// Motion state.
	ssg_pkg::motion_t          motion_q, motion_n;
	logic [COUNT_WIDTH-1:0]    done_q, done_n;
	logic [COUNT_WIDTH-1:0]    goal_q, goal_n;
	logic                      endless_q, endless_n;
	logic [PERIOD_WIDTH-1:0]   tick_q, tick_n;
	logic                      dir_q, dir_n;
	logic                      homed_q, homed_n;
	logic                      pulse_n, complete_n;

	// Helpers for the update.
	logic                      proc;
	logic                      sensor_active;
	logic                      can_move;
	logic                      running;
	logic [31:0]               period_wide;
	logic [PERIOD_WIDTH-1:0]   period;
	logic [PERIOD_WIDTH-1:0]   tick_inc;
	logic                      tick_hit;
	logic [COUNT_WIDTH-1:0]    done_inc;
	logic [COUNT_WIDTH-1:0]    goal_move;
	logic [COUNT_WIDTH-1:0]    goal_home;
	logic [31:0]               offset_wide;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_period_q <= ssg_pkg::STEP_PERIOD_RST;
			home_offset_q <= ssg_pkg::HOME_OFFSET_RST;
		end else if (cfg_valid) begin
			if (cfg_index == ssg_pkg::REG_STEP_PERIOD) begin
				step_period_q <= cfg_data[ssg_pkg::PERIOD_REG_W-1:0];
			end else if (cfg_index == ssg_pkg::REG_HOME_OFFSET) begin
				home_offset_q <= cfg_data[ssg_pkg::OFFSET_REG_W-1:0];
			end
		end
	end

	// The input register advances whenever the result register is free or is
	// being emptied in this cycle.
	assign proc     = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1         <= kind;
			steps_s1        <= steps;
			direction_s1    <= direction;
			sensor_level_s1 <= sensor_level;
		end
	end

	// A zero period behaves as one tick; the tick counter wraps within its width,
	// and a wrap to zero also counts as reaching the period.
	assign period_wide   = {{(32 - ssg_pkg::PERIOD_REG_W){1'b0}}, step_period_q};
	assign period        = (period_wide[PERIOD_WIDTH-1:0] == '0) ?
	                       PERIOD_WIDTH'(1) : period_wide[PERIOD_WIDTH-1:0];
	assign tick_inc      = tick_q + PERIOD_WIDTH'(1);
	assign tick_hit      = (tick_inc >= period) || (tick_inc == '0);
	assign done_inc      = done_q + COUNT_WIDTH'(1);

	// Goals that do not fit the step counter saturate at its top value.
	assign offset_wide   = {{(32 - ssg_pkg::OFFSET_REG_W){1'b0}}, home_offset_q};
	assign goal_move     = (steps_s1 > CNT_MAX32) ? '1 : steps_s1[COUNT_WIDTH-1:0];
	assign goal_home     = (offset_wide > CNT_MAX32) ? '1 : offset_wide[COUNT_WIDTH-1:0];

	assign sensor_active = !sensor_level_s1;
	assign can_move      = (motion_q == ssg_pkg::ST_IDLE) || (motion_q == ssg_pkg::ST_HOME);
	assign running       = (motion_q == ssg_pkg::ST_MOVING) || (motion_q == ssg_pkg::ST_SEEK) ||
	                       (motion_q == ssg_pkg::ST_OFFSET);

	always_comb begin
		motion_n   = motion_q;
		done_n     = done_q;
		goal_n     = goal_q;
		endless_n  = endless_q;
		tick_n     = tick_q;
		dir_n      = dir_q;
		homed_n    = homed_q;
		pulse_n    = 1'b0;
		complete_n = 1'b0;
		case (kind_s1)
			ssg_pkg::KIND_TICK: begin
				if (running) begin
					if (tick_hit) begin
						tick_n  = '0;
						pulse_n = 1'b1;
						done_n  = done_inc;
						if (motion_q == ssg_pkg::ST_SEEK) begin
							// Sensor found after a seek step: turn clockwise and
							// start the offset move, or finish if there is none.
							if (sensor_active) begin
								dir_n     = 1'b0;
								done_n    = '0;
								goal_n    = goal_home;
								endless_n = 1'b0;
								if (goal_home == '0) begin
									motion_n   = ssg_pkg::ST_HOME;
									homed_n    = 1'b1;
									complete_n = 1'b1;
								end else begin
									motion_n = ssg_pkg::ST_OFFSET;
								end
							end
						end else if (motion_q == ssg_pkg::ST_OFFSET) begin
							if (done_inc >= goal_q) begin
								motion_n   = ssg_pkg::ST_HOME;
								homed_n    = 1'b1;
								complete_n = 1'b1;
							end
						end else if (!endless_q && (done_inc >= goal_q)) begin
							motion_n = ssg_pkg::ST_IDLE;
						end
					end else begin
						tick_n = tick_inc;
					end
				end
			end
			ssg_pkg::KIND_MOVE, ssg_pkg::KIND_CONTINUOUS: begin
				if (can_move) begin
					dir_n     = direction_s1;
					done_n    = '0;
					endless_n = (kind_s1 == ssg_pkg::KIND_CONTINUOUS);
					goal_n    = (kind_s1 == ssg_pkg::KIND_MOVE) ? goal_move : '0;
					tick_n    = '0;
					motion_n  = ssg_pkg::ST_MOVING;
				end
			end
			ssg_pkg::KIND_HOME: begin
				if (motion_q == ssg_pkg::ST_IDLE) begin
					homed_n   = 1'b0;
					done_n    = '0;
					tick_n    = '0;
					if (sensor_active) begin
						// Already in the groove: no seek, go straight to the offset.
						dir_n     = 1'b0;
						goal_n    = goal_home;
						endless_n = 1'b0;
						if (goal_home == '0) begin
							motion_n   = ssg_pkg::ST_HOME;
							homed_n    = 1'b1;
							complete_n = 1'b1;
						end else begin
							motion_n = ssg_pkg::ST_OFFSET;
						end
					end else begin
						dir_n     = 1'b1;
						goal_n    = '0;
						endless_n = 1'b1;
						motion_n  = ssg_pkg::ST_SEEK;
					end
				end
			end
			ssg_pkg::KIND_STOP: begin
				motion_n = ssg_pkg::ST_IDLE;
				tick_n   = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_q  <= ssg_pkg::ST_IDLE;
			done_q    <= '0;
			goal_q    <= '0;
			endless_q <= 1'b0;
			tick_q    <= '0;
			dir_q     <= 1'b0;
			homed_q   <= 1'b0;
		end else if (proc) begin
			motion_q  <= motion_n;
			done_q    <= done_n;
			goal_q    <= goal_n;
			endless_q <= endless_n;
			tick_q    <= tick_n;
			dir_q     <= dir_n;
			homed_q   <= homed_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (proc) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			step_pulse      <= pulse_n;
			dir_level       <= dir_n;
			mode            <= ssg_pkg::mode_code(motion_n);
			homed           <= homed_n;
			homing_complete <= complete_n;
		end
	end

	// The input side only waits when both registers hold a beat.
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid && !out_ready))
		else $error("input stalled while a register was free");

	// A stop command always leaves the block idle.
	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && kind_s1 == ssg_pkg::KIND_STOP) |=> (motion_q == ssg_pkg::ST_IDLE))
		else $error("stop did not return to idle");

	// Pulses come only from a tick while the motor runs.
	a_pulse_running: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && !(running && kind_s1 == ssg_pkg::KIND_TICK)) |=> !step_pulse)
		else $error("step pulse without a running tick");

	// A finished homing reports homed and the at-home status together.
	a_complete_home: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && homing_complete) |-> (homed && mode == ssg_pkg::MODE_AT_HOME))
		else $error("homing complete without at-home status");

	// The offset move is always a finite clockwise move.
	a_offset_finite: assert property (@(posedge clk) disable iff (!arst_n)
		(motion_q == ssg_pkg::ST_OFFSET) |-> (!endless_q && !dir_q))
		else $error("offset phase is endless or counter-clockwise");

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stepper step generator with homing.
// Holds its own motion predictor and drives the block through ssg_pkg types and codes.

module testbench;
	import ssg_pkg::*;

	// One command or tick beat as it is offered on the input channel.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [STEPS_W-1:0] steps;
		logic               direction;
		logic               sensor_level;
	} motor_cmd_t;

	// One status beat as it leaves the block.
	typedef struct packed {
		logic              step_pulse;
		logic              dir_level;
		logic [MODE_W-1:0] mode;
		logic              homed;
		logic              homing_complete;
	} motor_status_t;

	// Register indexes that the block decodes to nothing.
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

	// Command codes that the block decodes to no action.
	localparam logic [KIND_W-1:0] KIND_RSVD_5 = 3'd5;
	localparam logic [KIND_W-1:0] KIND_RSVD_6 = 3'd6;
	localparam logic [KIND_W-1:0] KIND_RSVD_7 = 3'd7;

	localparam int IDLE_PCT     = 35;
	localparam int HOLD_CYCLES  = 100;
	localparam int SETTLE_CYCLES = 6;
	localparam int TICK_CAP     = 48;
	localparam int TIMEOUT_NS   = 2_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [KIND_W-1:0]      kind = KIND_TICK;
	logic [STEPS_W-1:0]     steps = '0;
	logic                   direction = 1'b0;
	logic                   sensor_level = 1'b1;

	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   step_pulse;
	logic                   dir_level;
	logic [MODE_W-1:0]      mode;
	logic                   homed;
	logic                   homing_complete;

	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_STEP_PERIOD;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	stepper_step_generator_homing i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.steps           (steps),
		.direction       (direction),
		.sensor_level    (sensor_level),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.step_pulse      (step_pulse),
		.dir_level       (dir_level),
		.mode            (mode),
		.homed           (homed),
		.homing_complete (homing_complete),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #4 clk = ~clk;

	// Commands waiting to be offered, and status beats the predictor has worked out
	// for accepted commands but that have not come out of the block yet.
	motor_cmd_t    cmd_queue[$];
	motor_status_t pending_status[$];
	motor_cmd_t    shown_cmd;
	int            errors = 0;
	int            planned = 0;

	// Control from the stimulus process: random idling on both channels, and a
	// request counter that makes the result side hold off for a long stretch.
	bit idle_en = 1'b1;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_count = 0;

	// Predictor copy of the registers and of the motion state, at reset values.
	logic [PERIOD_REG_W-1:0] cfg_period = STEP_PERIOD_RST;
	logic [OFFSET_REG_W-1:0] cfg_offset = HOME_OFFSET_RST;
	logic [MODE_W-1:0]       mot_mode = MODE_IDLE;
	logic [STEPS_W-1:0]      mot_count = '0;
	logic [STEPS_W-1:0]      mot_target = '0;
	logic                    mot_endless = 1'b0;
	logic [PERIOD_REG_W-1:0] mot_ticks = '0;
	logic                    mot_dir = 1'b0;
	logic                    mot_homed = 1'b0;

	// Turns the motor clockwise for the home offset. With a zero offset homing is
	// already over, which the caller reports as the completion flag.
	function automatic logic enter_offset();
		mot_dir = 1'b0;
		mot_count = '0;
		mot_target = STEPS_W'(cfg_offset);
		mot_endless = 1'b0;
		mot_ticks = '0;
		if (cfg_offset == '0) begin
			mot_mode = MODE_AT_HOME;
			mot_homed = 1'b1;
			return 1'b1;
		end
		mot_mode = MODE_OFFSET;
		return 1'b0;
	endfunction

	// Applies one accepted beat to the predicted motion state and returns the
	// status beat that the block must answer with.
	function automatic motor_status_t advance_motor(motor_cmd_t c);
		motor_status_t r;
		logic [PERIOD_REG_W-1:0] period;
		logic [PERIOD_REG_W-1:0] next_tick;
		logic sensor_on;
		logic running;
		r = '0;
		sensor_on = !c.sensor_level;
		running = (mot_mode == MODE_MOVING) || (mot_mode == MODE_SEEK) ||
			(mot_mode == MODE_OFFSET);
		case (c.kind)
			KIND_TICK: begin
				if (running) begin
					// A zero period behaves like a period of one tick.
					period = (cfg_period == '0) ? PERIOD_REG_W'(1) : cfg_period;
					next_tick = mot_ticks + 1'b1;
					if (next_tick >= period || next_tick == '0) begin
						mot_ticks = '0;
						r.step_pulse = 1'b1;
						mot_count = mot_count + 1'b1;
						if (mot_mode == MODE_SEEK) begin
							if (sensor_on)
								r.homing_complete = enter_offset();
						end else if (mot_mode == MODE_OFFSET) begin
							if (mot_count >= mot_target) begin
								mot_mode = MODE_AT_HOME;
								mot_homed = 1'b1;
								r.homing_complete = 1'b1;
							end
						end else if (!mot_endless && mot_count >= mot_target) begin
							mot_mode = MODE_IDLE;
						end
					end else begin
						mot_ticks = next_tick;
					end
				end
			end
			KIND_MOVE, KIND_CONTINUOUS: begin
				if (mot_mode == MODE_IDLE || mot_mode == MODE_AT_HOME) begin
					mot_dir = c.direction;
					mot_count = '0;
					mot_endless = (c.kind == KIND_CONTINUOUS);
					mot_target = (c.kind == KIND_MOVE) ? c.steps : '0;
					mot_ticks = '0;
					mot_mode = MODE_MOVING;
				end
			end
			KIND_HOME: begin
				if (mot_mode == MODE_IDLE) begin
					mot_homed = 1'b0;
					if (sensor_on) begin
						// Already in the groove: no seek at all.
						r.homing_complete = enter_offset();
					end else begin
						mot_dir = 1'b1;
						mot_count = '0;
						mot_target = '0;
						mot_endless = 1'b1;
						mot_ticks = '0;
						mot_mode = MODE_SEEK;
					end
				end
			end
			KIND_STOP: begin
				mot_mode = MODE_IDLE;
				mot_ticks = '0;
			end
			default: begin
			end
		endcase
		r.dir_level = mot_dir;
		r.mode = mot_mode;
		r.homed = mot_homed;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Driver. The predictor runs on each accepted beat; the next beat is offered
	// only once the current one is gone, so valid never drops while waiting.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				pending_status.push_back(advance_motor(shown_cmd));
			if (!in_valid || in_ready) begin
				if (cmd_queue.size() != 0 && !(idle_en && $urandom_range(99) < IDLE_PCT)) begin
					shown_cmd = cmd_queue.pop_front();
					kind <= shown_cmd.kind;
					steps <= shown_cmd.steps;
					direction <= shown_cmd.direction;
					sensor_level <= shown_cmd.sensor_level;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Each status beat is matched against the oldest prediction. A
	// fresh hold-off request takes ready low until the hold counter has run down.
	always @(posedge clk or negedge arst_n) begin
		motor_status_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_status.size() == 0) begin
					$display("%0t ns: status beat with nothing predicted, got %0d/%0d/%0d/%0d/%0d",
						$time, step_pulse, dir_level, mode, homed, homing_complete);
					errors++;
				end else begin
					want = pending_status.pop_front();
					check_field("step_pulse", 8'(want.step_pulse), 8'(step_pulse));
					check_field("dir_level", 8'(want.dir_level), 8'(dir_level));
					check_field("mode", 8'(want.mode), 8'(mode));
					check_field("homed", 8'(want.homed), 8'(homed));
					check_field("homing_complete", 8'(want.homing_complete), 8'(homing_complete));
				end
			end
			if (hold_req != hold_ack) begin
				hold_ack <= hold_req;
				hold_count <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_count != 0) begin
				hold_count <= hold_count - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	task automatic add_cmd(input logic [KIND_W-1:0] k, input logic [STEPS_W-1:0] n,
		input logic d, input logic s);
		cmd_queue.push_back('{kind: k, steps: n, direction: d, sensor_level: s});
		planned++;
	endtask

	// Ticks carry random don't-care fields; the sensor reads active at the given rate.
	task automatic add_ticks(input int count, input int active_pct);
		repeat (count)
			add_cmd(KIND_TICK, $urandom, 1'($urandom_range(1)),
				!($urandom_range(99) < active_pct));
	endtask

	// Ticks needed for a number of pulses at the current period, kept short.
	function automatic int tick_budget(input longint pulses);
		longint per;
		longint total;
		per = (cfg_period == '0) ? 1 : longint'(cfg_period);
		total = pulses * per + $urandom_range(2);
		return (total > TICK_CAP) ? TICK_CAP : int'(total);
	endfunction

	// One random scenario. Half are move or homing sequences with a capped number
	// of ticks; the rest are continuous runs, stops and arbitrary beats.
	task automatic add_random_run();
		logic [STEPS_W-1:0] n;
		int pick;
		pick = $urandom_range(9);
		if (pick <= 2) begin
			n = ($urandom_range(7) == 0) ? STEPS_W'($urandom) : STEPS_W'($urandom_range(6));
			add_cmd(KIND_MOVE, n, 1'($urandom_range(1)), 1'($urandom_range(1)));
			add_ticks(tick_budget((n > 64) ? 64 : longint'(n) + 1), 50);
		end else if (pick <= 4) begin
			add_cmd(KIND_CONTINUOUS, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
			add_ticks($urandom_range(1, 20), 50);
			add_cmd(KIND_STOP, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
		end else if (pick <= 6) begin
			// Homing is only taken in idle, so a stop often leads in.
			if ($urandom_range(1))
				add_cmd(KIND_STOP, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
			add_cmd(KIND_HOME, $urandom, 1'($urandom_range(1)), !($urandom_range(4) == 0));
			add_ticks(tick_budget(longint'(cfg_offset) + 4), 30);
		end else if (pick == 7) begin
			add_cmd(KIND_STOP, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
		end else begin
			repeat ($urandom_range(1, 3))
				add_cmd(KIND_W'($urandom_range(7)), $urandom, 1'($urandom_range(1)),
					1'($urandom_range(1)));
		end
	endtask

	// Register writes happen only with the block drained. The predictor copy is
	// updated on the accepting edge.
	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_STEP_PERIOD: cfg_period = data[PERIOD_REG_W-1:0];
			REG_HOME_OFFSET: cfg_offset = data[OFFSET_REG_W-1:0];
			default: begin
			end
		endcase
		cfg_valid <= 1'b0;
	endtask

	// Waits until every queued command is accepted and every status beat has
	// come out, then lets the two-stage pipeline settle.
	task automatic drain();
		do
			@(negedge clk);
		while (cmd_queue.size() != 0 || in_valid || pending_status.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One random phase under a fresh register setting. Upper data bits are junk
	// that the block has to ignore.
	task automatic run_phase(input logic [PERIOD_REG_W-1:0] period,
		input logic [OFFSET_REG_W-1:0] offset,
		input bit with_idle, input bit with_hold, input int count);
		write_register(REG_STEP_PERIOD, {12'($urandom), period});
		write_register(REG_HOME_OFFSET, {16'($urandom), offset});
		@(negedge clk);
		idle_en = with_idle;
		planned = 0;
		while (planned < count)
			add_random_run();
		if (with_hold)
			hold_req++;
		drain();
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings (period 1000, offset 100): undefined kinds, commands that
		// are refused while busy, and homing that starts on the sensor.
		add_cmd(KIND_RSVD_5, '1, 1'b1, 1'b0);
		add_cmd(KIND_RSVD_6, '0, 1'b0, 1'b1);
		add_cmd(KIND_RSVD_7, $urandom, 1'b1, 1'b1);
		add_cmd(KIND_STOP, $urandom, 1'b0, 1'b1);
		add_cmd(KIND_HOME, $urandom, 1'b0, 1'b0);
		add_cmd(KIND_HOME, $urandom, 1'b1, 1'b1);
		add_cmd(KIND_MOVE, 32'd5, 1'b1, 1'b1);
		add_cmd(KIND_TICK, $urandom, 1'b1, 1'b0);
		add_cmd(KIND_STOP, $urandom, 1'b0, 1'b1);
		drain();

		// Period of one tick and no home offset, written with junk in the upper bits,
		// plus a write to each undecoded index.
		write_register(REG_STEP_PERIOD, 32'hFFF0_0001);
		write_register(REG_HOME_OFFSET, 32'hABCD_0000);
		write_register(REG_SPARE_LO, $urandom);
		write_register(REG_SPARE_HI, $urandom);
		@(negedge clk);
		// A zero-step move still gives one pulse.
		add_cmd(KIND_MOVE, 32'd0, 1'b0, 1'b1);
		add_cmd(KIND_TICK, $urandom, 1'b1, 1'b1);
		add_cmd(KIND_TICK, $urandom, 1'b0, 1'b0);
		add_cmd(KIND_MOVE, 32'd2, 1'b1, 1'b0);
		add_ticks(2, 50);
		// Sensor active on the command with zero offset: homed at once.
		add_cmd(KIND_HOME, $urandom, 1'b1, 1'b0);
		add_cmd(KIND_TICK, $urandom, 1'b1, 1'b0);
		add_cmd(KIND_HOME, $urandom, 1'b0, 1'b1);
		add_cmd(KIND_MOVE, 32'd1, 1'b0, 1'b1);
		add_cmd(KIND_TICK, $urandom, 1'b0, 1'b1);
		// Seek that finds the groove on its second pulse.
		add_cmd(KIND_HOME, $urandom, 1'b0, 1'b1);
		add_cmd(KIND_TICK, $urandom, 1'b0, 1'b1);
		add_cmd(KIND_TICK, $urandom, 1'b0, 1'b0);
		add_cmd(KIND_STOP, $urandom, 1'b1, 1'b0);
		add_cmd(KIND_CONTINUOUS, $urandom, 1'b1, 1'b1);
		add_ticks(2, 50);
		add_cmd(KIND_STOP, $urandom, 1'b0, 1'b1);
		// The all-ones count is an ordinary long move.
		add_cmd(KIND_MOVE, '1, 1'b1, 1'b1);
		add_cmd(KIND_TICK, $urandom, 1'b0, 1'b1);
		add_cmd(KIND_STOP, $urandom, 1'b0, 1'b1);
		drain();

		// Random phases. One has the long result hold-off with the sender still
		// pushing, one runs without any idling; the last ones use the extremes.
		run_phase(20'd2, 16'd3, 1'b1, 1'b0, 50);
		run_phase(20'd1, 16'd1, 1'b1, 1'b0, 50);
		run_phase(20'd0, 16'd2, 1'b1, 1'b0, 50);
		run_phase(20'd3, 16'd0, 1'b1, 1'b0, 50);
		run_phase(20'd1, 16'd5, 1'b1, 1'b1, 60);
		run_phase(20'd2, 16'd2, 1'b0, 1'b0, 60);
		run_phase(20'd5, 16'd1, 1'b1, 1'b0, 50);
		run_phase(20'hFFFFF, 16'hFFFF, 1'b1, 1'b0, 40);
		run_phase(20'd1000000, 16'd0, 1'b1, 1'b0, 40);
		run_phase(20'd1, 16'hFFFF, 1'b1, 1'b0, 50);

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Hard stop in case the block hangs a handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
